>>> design/gprd_pkg.sv
`timescale 1ns / 1ps

package gprd_pkg;

  // report ids
  localparam logic [7:0] ID_SUBCMD = 8'h21;
  localparam logic [7:0] ID_FULL   = 8'h30;
  localparam logic [7:0] ID_SIMPLE = 8'h3F;

  // capture window and minimum lengths
  localparam int KEEP_BYTES     = 14;
  localparam int FULL_MIN_LEN   = 49;
  localparam int SIMPLE_MIN_LEN = 12;
  localparam int POS_MAX        = 63;

  // stick scaling: (raw - center) * max / divisor, divide by reciprocal multiply
  localparam int CENTER      = 2000;
  localparam int DIVISOR     = 1500;
  localparam int RECIP_SHIFT = 37;
  localparam logic [26:0] RECIP_MULT =
    27'(((64'd1 << RECIP_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  localparam int NUM_STICKS = 4;

  typedef enum logic [1:0] {
    ST_FULL    = 2'd0,
    ST_SIMPLE  = 2'd1,
    ST_SHORT   = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef logic signed [1:0] axis_t;

  // classified report handed from front to back
  typedef struct packed {
    status_t                         status;
    logic [7:0]                      id;
    logic [7:0]                      timer;
    logic [7:0]                      battery;
    logic [7:0]                      ack;
    logic [15:0]                     buttons;
    axis_t                           dpad_v;
    axis_t                           dpad_h;
    logic                            scale;
    logic [NUM_STICKS-1:0][15:0]     sticks;
  } frame_t;

  // decoded result
  typedef struct packed {
    status_t                         status;
    logic [7:0]                      id;
    logic [7:0]                      timer;
    logic [7:0]                      battery;
    logic [7:0]                      ack;
    logic [15:0]                     buttons;
    axis_t                           dpad_v;
    axis_t                           dpad_h;
    logic [NUM_STICKS-1:0][15:0]     sticks;
  } result_t;

  // three-level axis: low xor negated high
  function automatic axis_t dpad_axis(input logic lo, input logic hi);
    return axis_t'({hi, lo ^ hi});
  endfunction

endpackage

>>> design/gprd_fifo.sv
`timescale 1ns / 1ps

module gprd_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  T                             din,
  output logic                         full,
  input  logic                         pop,
  output T                             dout,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  T                mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CW'(DEPTH));
  assign count   = cnt_r;
  assign dout    = mem_r[rd_ptr_r];
  assign do_pop  = pop && !empty;
  assign do_push = push && (!full || do_pop);

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  // a beat offered while full with no pop would be dropped
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("fifo push while full");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fifo count out of range");

endmodule

>>> design/gprd_front.sv
`timescale 1ns / 1ps

module gprd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  input  logic [7:0]      in_data_byte,
  input  logic            in_last_byte,
  input  logic            stall,
  output logic            frame_valid,
  output gprd_pkg::frame_t frame
);

  logic [5:0]  pos_r, pos_nxt;
  logic [7:0]  cap_r [gprd_pkg::KEEP_BYTES];
  logic [7:0]  c     [gprd_pkg::KEEP_BYTES];
  logic [6:0]  len;
  logic        fire;

  assign fire        = in_push && !stall;
  assign frame_valid = fire && in_last_byte;
  assign len         = {1'b0, pos_r} + 7'd1;

  // byte position, saturating, cleared after the last beat
  always_comb begin
    pos_nxt = pos_r;
    if (fire) begin
      if (in_last_byte) begin
        pos_nxt = '0;
      end else if (pos_r != 6'(gprd_pkg::POS_MAX)) begin
        pos_nxt = pos_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // keep the head of the report
  always_ff @(posedge clk) begin
    if (fire && (pos_r < 6'(gprd_pkg::KEEP_BYTES))) begin
      cap_r[pos_r[3:0]] <= in_data_byte;
    end
  end

  // captured bytes with the current beat merged in
  always_comb begin
    for (int i = 0; i < gprd_pkg::KEEP_BYTES; i++) begin
      c[i] = (pos_r == 6'(i)) ? in_data_byte : cap_r[i];
    end
  end

  // classify the report and pull out its raw fields
  always_comb begin
    frame        = '0;
    frame.id     = c[0];
    frame.status = gprd_pkg::ST_UNKNOWN;
    unique case (c[0]) inside
      gprd_pkg::ID_SUBCMD, gprd_pkg::ID_FULL: begin
        if (len < 7'(gprd_pkg::FULL_MIN_LEN)) begin
          frame.status = gprd_pkg::ST_SHORT;
        end else begin
          frame.status    = gprd_pkg::ST_FULL;
          frame.timer     = c[1];
          frame.battery   = c[2];
          frame.ack       = (c[0] == gprd_pkg::ID_SUBCMD) ? c[13] : 8'd0;
          frame.buttons   = {c[5][7:6], c[4][5:0], c[3]};
          frame.dpad_v    = gprd_pkg::dpad_axis(c[5][0], c[5][1]);
          frame.dpad_h    = gprd_pkg::dpad_axis(c[5][2], c[5][3]);
          frame.scale     = 1'b1;
          frame.sticks[0] = {4'd0, c[7][3:0], c[6]};
          frame.sticks[1] = {4'd0, c[8], c[7][7:4]};
          frame.sticks[2] = {4'd0, c[10][3:0], c[9]};
          frame.sticks[3] = {4'd0, c[11], c[10][7:4]};
        end
      end
      gprd_pkg::ID_SIMPLE: begin
        if (len < 7'(gprd_pkg::SIMPLE_MIN_LEN)) begin
          frame.status = gprd_pkg::ST_SHORT;
        end else begin
          frame.status      = gprd_pkg::ST_SIMPLE;
          frame.buttons[5]  = c[1][4];
          frame.buttons[4]  = c[1][5];
          frame.buttons[8]  = c[2][0];
          frame.buttons[9]  = c[2][1];
          frame.buttons[11] = c[2][2];
          frame.buttons[10] = c[2][3];
          frame.buttons[15:12] = c[2][7:4];
          frame.dpad_v      = gprd_pkg::dpad_axis(c[1][0], c[1][3]);
          frame.dpad_h      = gprd_pkg::dpad_axis(c[1][1], c[1][2]);
          frame.sticks[0]   = {c[5], c[4]};
          frame.sticks[1]   = {c[7], c[6]};
          frame.sticks[2]   = {c[9], c[8]};
          frame.sticks[3]   = {c[11], c[10]};
        end
      end
      default: begin
        frame.status = gprd_pkg::ST_UNKNOWN;
      end
    endcase
  end

  // position restarts after every report
  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_last_byte) |=> (pos_r == 6'd0))
    else $error("byte position not cleared after last beat");

endmodule

>>> design/gprd_back.sv
`timescale 1ns / 1ps

module gprd_back #(
  parameter int unsigned STICK_MAX = 32767
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               frame_empty,
  input  gprd_pkg::frame_t   frame,
  output logic               frame_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output gprd_pkg::result_t  result
);

  localparam int          OUT_DEPTH = 4;
  localparam int          OCW       = $clog2(OUT_DEPTH + 1);
  localparam logic [14:0] SMAX      = 15'(STICK_MAX);
  localparam int          NS        = gprd_pkg::NUM_STICKS;

  // stage 1: offset and scale by max
  logic                    v1_r;
  gprd_pkg::frame_t        frm1_r;
  logic [NS-1:0]           sgn1_r;
  logic [NS-1:0][26:0]     prod1_r;
  logic [NS-1:0]           sgn1_nxt;
  logic [NS-1:0][26:0]     prod1_nxt;

  // stage 2: divide by reciprocal multiply
  logic                    v2_r;
  gprd_pkg::frame_t        frm2_r;
  logic [NS-1:0]           sgn2_r;
  logic [NS-1:0][15:0]     quo2_r;
  logic [NS-1:0][15:0]     quo2_nxt;

  gprd_pkg::result_t       res_nxt;
  logic                    ofifo_full;
  logic [OCW-1:0]          ofifo_cnt;
  logic [3:0]              in_flight;
  logic                    pull;

  // reserve result space for everything already in the pipe
  assign in_flight = 4'(v1_r) + 4'(v2_r) + 4'(ofifo_cnt);
  assign pull      = !frame_empty &&
                     ((in_flight < 4'(OUT_DEPTH)) || (out_pop && !out_empty));
  assign frame_pop = pull;

  // centered magnitude times max
  always_comb begin
    logic signed [12:0] d;
    logic [11:0]        mag;
    for (int i = 0; i < NS; i++) begin
      d            = signed'({1'b0, frame.sticks[i][11:0]}) - 13'(gprd_pkg::CENTER);
      sgn1_nxt[i]  = d[12];
      mag          = d[12] ? 12'(-d) : 12'(d);
      prod1_nxt[i] = 27'(mag) * 27'(SMAX);
    end
  end

  // quotient by 1500, truncated
  always_comb begin
    logic [53:0] wide;
    for (int i = 0; i < NS; i++) begin
      wide        = 54'(prod1_r[i]) * 54'(gprd_pkg::RECIP_MULT);
      quo2_nxt[i] = wide[gprd_pkg::RECIP_SHIFT +: 16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= pull;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    frm1_r  <= frame;
    sgn1_r  <= sgn1_nxt;
    prod1_r <= prod1_nxt;
    frm2_r  <= frm1_r;
    sgn2_r  <= sgn1_r;
    quo2_r  <= quo2_nxt;
  end

  // clamp, sign, vertical flip
  always_comb begin
    logic [15:0] mag;
    logic        neg;
    res_nxt.status  = frm2_r.status;
    res_nxt.id      = frm2_r.id;
    res_nxt.timer   = frm2_r.timer;
    res_nxt.battery = frm2_r.battery;
    res_nxt.ack     = frm2_r.ack;
    res_nxt.buttons = frm2_r.buttons;
    res_nxt.dpad_v  = frm2_r.dpad_v;
    res_nxt.dpad_h  = frm2_r.dpad_h;
    for (int i = 0; i < NS; i++) begin
      mag = (quo2_r[i] > 16'(SMAX)) ? 16'(SMAX) : quo2_r[i];
      neg = sgn2_r[i] ^ (i % 2 == 1);
      if (frm2_r.scale) begin
        res_nxt.sticks[i] = neg ? 16'(-mag) : mag;
      end else begin
        res_nxt.sticks[i] = frm2_r.sticks[i];
      end
    end
  end

  // result queue
  gprd_fifo #(
    .T     (gprd_pkg::result_t),
    .DEPTH (OUT_DEPTH)
  ) u_ofifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (v2_r),
    .din   (res_nxt),
    .full  (ofifo_full),
    .pop   (out_pop),
    .dout  (result),
    .empty (out_empty),
    .count (ofifo_cnt)
  );

  a_pull_enters: assert property (@(posedge clk) disable iff (!rst_n)
    pull |=> v1_r)
    else $error("pulled frame did not enter the pipe");

  a_room_kept: assert property (@(posedge clk) disable iff (!rst_n)
    !(v2_r && ofifo_full && !out_pop))
    else $error("result reached a full queue");

endmodule

>>> design/gamepad_report_decoder.sv
`timescale 1ns / 1ps

// Report bytes enter one per cycle on the input queue port while in_full is
// low, the report id first; in_last_byte marks the final byte, and that beat
// yields exactly one result, which goes through the frame queue and the two
// scaling stages to the result queue. The front part counts and captures the
// first 14 bytes and classifies each report into a two-entry frame queue; the
// back part scales the four stick values in a two-stage multiply pipeline
// (offset times STICK_MAX, then a reciprocal multiply for the divide by 1500)
// and holds up to four results. in_full rises only while the frame queue is
// full, which happens when results are left waiting and further reports end.
module gamepad_report_decoder #(
  parameter int unsigned STICK_MAX = 32767
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [1:0]         out_report_status,
  output logic [7:0]         out_report_id,
  output logic [7:0]         out_timer_value,
  output logic [7:0]         out_battery_connection,
  output logic [7:0]         out_subcommand_ack,
  output logic [15:0]        out_button_bits,
  output logic signed [1:0]  out_dpad_vertical,
  output logic signed [1:0]  out_dpad_horizontal,
  output logic signed [15:0] out_left_horizontal,
  output logic signed [15:0] out_left_vertical,
  output logic signed [15:0] out_right_horizontal,
  output logic signed [15:0] out_right_vertical
);

  localparam int MID_DEPTH = 2;

  gprd_pkg::frame_t   frm_in;
  gprd_pkg::frame_t   frm_out;
  gprd_pkg::result_t  res;
  logic               frm_valid;
  logic               mid_full;
  logic               mid_empty;
  logic               mid_pop;

  assign in_full = mid_full;

  // byte intake and classification
  gprd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .stall        (mid_full),
    .frame_valid  (frm_valid),
    .frame        (frm_in)
  );

  // frame queue between front and back
  gprd_fifo #(
    .T     (gprd_pkg::frame_t),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (frm_valid),
    .din   (frm_in),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (frm_out),
    .empty (mid_empty),
    .count ()
  );

  // stick scaling and result queue
  gprd_back #(
    .STICK_MAX (STICK_MAX)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_empty (mid_empty),
    .frame       (frm_out),
    .frame_pop   (mid_pop),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .result      (res)
  );

  assign out_report_status      = res.status;
  assign out_report_id          = res.id;
  assign out_timer_value        = res.timer;
  assign out_battery_connection = res.battery;
  assign out_subcommand_ack     = res.ack;
  assign out_button_bits        = res.buttons;
  assign out_dpad_vertical      = res.dpad_v;
  assign out_dpad_horizontal    = res.dpad_h;
  assign out_left_horizontal    = res.sticks[0];
  assign out_left_vertical      = res.sticks[1];
  assign out_right_horizontal   = res.sticks[2];
  assign out_right_vertical     = res.sticks[3];

endmodule

>>> tb/gamepad_report_checker.sv
`timescale 1ns / 1ps

module gamepad_report_checker #(
  parameter int STICK_MAX = 32767
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic [1:0]         out_report_status,
  input  logic [7:0]         out_report_id,
  input  logic [7:0]         out_timer_value,
  input  logic [7:0]         out_battery_connection,
  input  logic [7:0]         out_subcommand_ack,
  input  logic [15:0]        out_button_bits,
  input  logic signed [1:0]  out_dpad_vertical,
  input  logic signed [1:0]  out_dpad_horizontal,
  input  logic signed [15:0] out_left_horizontal,
  input  logic signed [15:0] out_left_vertical,
  input  logic signed [15:0] out_right_horizontal,
  input  logic signed [15:0] out_right_vertical,
  output int                 bad_decodes,
  output int                 reports_in_flight,
  output int                 reports_decoded
);

  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    gprd_pkg::status_t  status;
    logic [7:0]         id;
    logic [7:0]         timer;
    logic [7:0]         battery;
    logic [7:0]         ack;
    logic [15:0]        buttons;
    logic signed [1:0]  dpad_v;
    logic signed [1:0]  dpad_h;
    logic signed [15:0] lh;
    logic signed [15:0] lv;
    logic signed [15:0] rh;
    logic signed [15:0] rv;
  } decoded_t;

  // own copy of the report capture state
  logic [5:0] byte_pos;
  logic [7:0] kept [gprd_pkg::KEEP_BYTES];
  decoded_t   decoded_reports [$];

  initial begin
    bad_decodes       = 0;
    reports_in_flight = 0;
    reports_decoded   = 0;
  end

  // three-level axis: low bit xor negated high bit
  function automatic logic signed [1:0] axis_level(input logic lo, input logic hi);
    return {1'b0, lo} ^ (hi ? 2'b11 : 2'b00);
  endfunction

  // centre, scale toward zero, clamp, optionally negate
  function automatic logic signed [15:0] scale_axis(input logic [11:0] raw,
                                                    input bit negate);
    int v;
    v = ((int'(raw) - gprd_pkg::CENTER) * STICK_MAX) / gprd_pkg::DIVISOR;
    if (v > STICK_MAX) v = STICK_MAX;
    if (v < -STICK_MAX) v = -STICK_MAX;
    if (negate) v = -v;
    return 16'(v);
  endfunction

  function automatic decoded_t decode_report(input int len);
    decoded_t d;
    d = '0;
    d.id = kept[0];
    if (kept[0] == gprd_pkg::ID_SUBCMD || kept[0] == gprd_pkg::ID_FULL) begin
      if (len < gprd_pkg::FULL_MIN_LEN) begin
        d.status = gprd_pkg::ST_SHORT;
      end else begin
        d.status  = gprd_pkg::ST_FULL;
        d.timer   = kept[1];
        d.battery = kept[2];
        d.ack     = (kept[0] == gprd_pkg::ID_SUBCMD) ? kept[13] : 8'h00;
        d.buttons = {kept[5][7:6], kept[4][5:0], kept[3]};
        d.dpad_v  = axis_level(kept[5][0], kept[5][1]);
        d.dpad_h  = axis_level(kept[5][2], kept[5][3]);
        // four packed 12-bit sticks, verticals negated
        d.lh = scale_axis({kept[7][3:0], kept[6]}, 1'b0);
        d.lv = scale_axis({kept[8], kept[7][7:4]}, 1'b1);
        d.rh = scale_axis({kept[10][3:0], kept[9]}, 1'b0);
        d.rv = scale_axis({kept[11], kept[10][7:4]}, 1'b1);
      end
    end else if (kept[0] == gprd_pkg::ID_SIMPLE) begin
      if (len < gprd_pkg::SIMPLE_MIN_LEN) begin
        d.status = gprd_pkg::ST_SHORT;
      end else begin
        d.status  = gprd_pkg::ST_SIMPLE;
        // zl l capture home tl tr plus minus, then sl sr from byte 1
        d.buttons = {kept[2][7:4], kept[2][2], kept[2][3], kept[2][1], kept[2][0],
                     2'b00, kept[1][4], kept[1][5], 4'b0000};
        d.dpad_v  = axis_level(kept[1][0], kept[1][3]);
        d.dpad_h  = axis_level(kept[1][1], kept[1][2]);
        d.lh = {kept[5], kept[4]};
        d.lv = {kept[7], kept[6]};
        d.rh = {kept[9], kept[8]};
        d.rv = {kept[11], kept[10]};
      end
    end else begin
      d.status = gprd_pkg::ST_UNKNOWN;
    end
    return d;
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic last);
    int len;
    len = int'(byte_pos) + 1;
    if (int'(byte_pos) < gprd_pkg::KEEP_BYTES) kept[byte_pos] = b;
    if (int'(byte_pos) < gprd_pkg::POS_MAX) byte_pos = byte_pos + 6'd1;
    if (last) begin
      byte_pos = '0;
      decoded_reports.push_back(decode_report(len));
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got, inout bit bad);
    if (got !== want) begin
      bad = 1'b1;
      if (bad_decodes < MAX_SHOWN)
        $display("result %0d %s: expected %h, got %h", reports_decoded, name, want, got);
    end
  endtask

  task automatic check_result();
    decoded_t want;
    bit       bad;
    bad = 1'b0;
    if (decoded_reports.size() == 0) begin
      if (bad_decodes < MAX_SHOWN)
        $display("result %0d popped with no report pending, id %h", reports_decoded,
                 out_report_id);
      bad_decodes++;
    end else begin
      want = decoded_reports.pop_front();
      check_field("status", 16'(want.status), 16'(out_report_status), bad);
      check_field("report id", 16'(want.id), 16'(out_report_id), bad);
      check_field("timer", 16'(want.timer), 16'(out_timer_value), bad);
      check_field("battery", 16'(want.battery), 16'(out_battery_connection), bad);
      check_field("subcommand ack", 16'(want.ack), 16'(out_subcommand_ack), bad);
      check_field("buttons", want.buttons, out_button_bits, bad);
      check_field("dpad vertical", 16'(want.dpad_v), 16'(out_dpad_vertical), bad);
      check_field("dpad horizontal", 16'(want.dpad_h), 16'(out_dpad_horizontal), bad);
      check_field("left horizontal", want.lh, out_left_horizontal, bad);
      check_field("left vertical", want.lv, out_left_vertical, bad);
      check_field("right horizontal", want.rh, out_right_horizontal, bad);
      check_field("right vertical", want.rv, out_right_vertical, bad);
      if (bad) bad_decodes++;
    end
    reports_decoded++;
  endtask

  // watch both channels at the edge where beats are taken
  always @(posedge clk) begin
    if (!rst_n) begin
      byte_pos = '0;
      foreach (kept[i]) kept[i] = '0;
      decoded_reports.delete();
    end else begin
      if (out_pop && !out_empty) check_result();
      if (in_push && !in_full) take_byte(in_data_byte, in_last_byte);
    end
    reports_in_flight = decoded_reports.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int HALF_PERIOD    = 2;
  localparam int STICK_LIMIT    = 32767;
  localparam int RANDOM_BYTES   = 950;
  localparam int RANDOM_REPORTS = 16;
  localparam int HOLD_CYCLES    = 150;
  localparam int SETTLE_CYCLES  = 16;
  localparam int RUN_LIMIT_NS   = 4_000_000;

  typedef enum int {PH_STEADY, PH_SENDER_IDLE, PH_RECEIVER_STALL, PH_BOTH} pace_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [1:0]  out_report_status;
  logic [7:0]  out_report_id;
  logic [7:0]  out_timer_value;
  logic [7:0]  out_battery_connection;
  logic [7:0]  out_subcommand_ack;
  logic [15:0] out_button_bits;
  logic signed [1:0]  out_dpad_vertical;
  logic signed [1:0]  out_dpad_horizontal;
  logic signed [15:0] out_left_horizontal;
  logic signed [15:0] out_left_vertical;
  logic signed [15:0] out_right_horizontal;
  logic signed [15:0] out_right_vertical;

  int bad_decodes;
  int reports_in_flight;
  int reports_decoded;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;

  int bytes_sent = 0;
  int reports_sent = 0;
  int kind_count [4];
  logic [7:0] report_bytes [$];

  always #(HALF_PERIOD) clk = ~clk;

  gamepad_report_decoder #(.STICK_MAX(STICK_LIMIT)) DUT (.*);

  gamepad_report_checker #(.STICK_MAX(STICK_LIMIT)) u_checker (.*);

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("run timed out with %0d reports in flight", reports_in_flight);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // result side: random stalls plus an occasional long hold-off
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic set_pace(input pace_t p);
    case (p)
      PH_STEADY: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      PH_SENDER_IDLE: begin
        send_idle_pct = 45;
        recv_stall_pct = 0;
      end
      PH_RECEIVER_STALL: begin
        send_idle_pct = 0;
        recv_stall_pct = 45;
      end
      default: begin
        send_idle_pct = 11;
        recv_stall_pct = 11;
      end
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic make_report(input logic [7:0] id, input int len);
    report_bytes.delete();
    report_bytes.push_back(id);
    for (int i = 1; i < len; i++) report_bytes.push_back(8'($urandom_range(255)));
  endtask

  // pack four 12-bit stick values into bytes 6..11
  task automatic set_sticks(input logic [11:0] lh, input logic [11:0] lv,
                            input logic [11:0] rh, input logic [11:0] rv);
    report_bytes[6]  = lh[7:0];
    report_bytes[7]  = {lv[3:0], lh[11:8]};
    report_bytes[8]  = lv[11:4];
    report_bytes[9]  = rh[7:0];
    report_bytes[10] = {rv[3:0], rh[11:8]};
    report_bytes[11] = rv[11:4];
  endtask

  task automatic send_report();
    foreach (report_bytes[i]) push_byte(report_bytes[i], i == report_bytes.size() - 1);
    reports_sent++;
  endtask

  // stop offering bytes and let every pending result come out
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    wait (reports_in_flight == 0);
  endtask

  // stick raw values weighted toward centre and clamp edges
  function automatic logic [11:0] pick_raw();
    case ($urandom_range(7))
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'(2000 + $urandom_range(2) - 1);
      3: return 12'(500 + $urandom_range(2) - 1);
      4: return 12'(3500 + $urandom_range(2) - 1);
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  function automatic logic [7:0] pick_unknown_id();
    logic [7:0] id;
    do id = 8'($urandom_range(255));
    while (id == gprd_pkg::ID_SUBCMD || id == gprd_pkg::ID_FULL ||
           id == gprd_pkg::ID_SIMPLE);
    return id;
  endfunction

  initial begin : stimulus
    int         random_reports;
    int         r;
    logic [7:0] id;
    random_reports = 0;
    foreach (kind_count[i]) kind_count[i] = 0;
    while (!rst_n) @(posedge clk);
    set_pace(PH_STEADY);

    // directed: length edges, stick extremes, button and dpad corners
    make_report(gprd_pkg::ID_SUBCMD, 1);
    send_report();
    make_report(gprd_pkg::ID_FULL, gprd_pkg::FULL_MIN_LEN - 1);
    send_report();
    make_report(gprd_pkg::ID_FULL, gprd_pkg::FULL_MIN_LEN);
    report_bytes[3] = 8'hFF;
    report_bytes[4] = 8'hFF;
    report_bytes[5] = 8'hFF;
    set_sticks(12'd0, 12'd4095, 12'd4095, 12'd0);
    send_report();
    make_report(gprd_pkg::ID_SUBCMD, gprd_pkg::FULL_MIN_LEN);
    report_bytes[3] = 8'h00;
    report_bytes[4] = 8'h00;
    report_bytes[5] = 8'h00;
    report_bytes[13] = 8'hFF;
    set_sticks(12'd2000, 12'd500, 12'd3500, 12'd1999);
    send_report();
    make_report(gprd_pkg::ID_SUBCMD, 64);
    report_bytes[5] = 8'h05;
    set_sticks(12'd2001, 12'd3501, 12'd499, 12'd2000);
    send_report();
    // past the saturation point of the byte counter
    make_report(gprd_pkg::ID_FULL, 90);
    report_bytes[5] = 8'h0A;
    send_report();
    make_report(gprd_pkg::ID_SIMPLE, gprd_pkg::SIMPLE_MIN_LEN - 1);
    send_report();
    make_report(gprd_pkg::ID_SIMPLE, gprd_pkg::SIMPLE_MIN_LEN);
    report_bytes[1] = 8'hFF;
    report_bytes[2] = 8'hFF;
    report_bytes[4] = 8'h00;
    report_bytes[5] = 8'h80;
    report_bytes[6] = 8'hFF;
    report_bytes[7] = 8'h7F;
    report_bytes[8] = 8'h00;
    report_bytes[9] = 8'h00;
    report_bytes[10] = 8'hFF;
    report_bytes[11] = 8'hFF;
    send_report();
    make_report(gprd_pkg::ID_SIMPLE, gprd_pkg::SIMPLE_MIN_LEN);
    report_bytes[1] = 8'h00;
    report_bytes[2] = 8'h00;
    send_report();
    make_report(gprd_pkg::ID_SIMPLE, 30);
    send_report();
    make_report(8'h00, 1);
    send_report();
    make_report(8'hFF, 5);
    send_report();
    make_report(8'h20, gprd_pkg::FULL_MIN_LEN);
    send_report();

    // random: mostly well-formed reports, some short ones and stray ids
    while (bytes_sent < RANDOM_BYTES || random_reports < RANDOM_REPORTS) begin
      set_pace(pace_t'((random_reports / 4) % 4));
      if (random_reports == 6) begin
        // hold the output while short stray-id reports keep coming
        hold_request = 1'b1;
        repeat (16) begin
          make_report(pick_unknown_id(), $urandom_range(1, 2));
          send_report();
        end
      end
      if (random_reports == 12) drain();

      r = $urandom_range(99);
      if (r < 50) begin
        id = $urandom_range(1) ? gprd_pkg::ID_SUBCMD : gprd_pkg::ID_FULL;
        if ($urandom_range(19) == 0) make_report(id, $urandom_range(65, 100));
        else make_report(id, $urandom_range(gprd_pkg::FULL_MIN_LEN,
                                            gprd_pkg::FULL_MIN_LEN + 7));
        if ($urandom_range(3) != 0) set_sticks(pick_raw(), pick_raw(), pick_raw(), pick_raw());
        kind_count[gprd_pkg::ST_FULL]++;
      end else if (r < 70) begin
        make_report(gprd_pkg::ID_SIMPLE,
                    $urandom_range(gprd_pkg::SIMPLE_MIN_LEN, gprd_pkg::SIMPLE_MIN_LEN + 8));
        kind_count[gprd_pkg::ST_SIMPLE]++;
      end else if (r < 82) begin
        if ($urandom_range(1))
          make_report($urandom_range(1) ? gprd_pkg::ID_SUBCMD : gprd_pkg::ID_FULL,
                      $urandom_range(1, gprd_pkg::FULL_MIN_LEN - 1));
        else
          make_report(gprd_pkg::ID_SIMPLE, $urandom_range(1, gprd_pkg::SIMPLE_MIN_LEN - 1));
        kind_count[gprd_pkg::ST_SHORT]++;
      end else begin
        make_report(pick_unknown_id(), $urandom_range(1, 8));
        kind_count[gprd_pkg::ST_UNKNOWN]++;
      end
      send_report();
      random_reports++;
    end

    // wind down
    set_pace(PH_STEADY);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d bytes in %0d reports sent, %0d results compared", bytes_sent,
             reports_sent, reports_decoded);
    $display("random mix: %0d full, %0d simple, %0d short, %0d unknown id, with idle and hold-off",
             kind_count[gprd_pkg::ST_FULL], kind_count[gprd_pkg::ST_SIMPLE],
             kind_count[gprd_pkg::ST_SHORT], kind_count[gprd_pkg::ST_UNKNOWN]);
    if (reports_in_flight != 0)
      $display("%0d results never arrived", reports_in_flight);
    if (bad_decodes == 0 && reports_in_flight == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> gamepad_report_decoder.f
design/gprd_pkg.sv
design/gprd_fifo.sv
design/gprd_front.sv
design/gprd_back.sv
design/gamepad_report_decoder.sv
tb/gamepad_report_checker.sv
tb/testbench.sv
